FILE: hw/rtl/intel_hex_record_loader_assert.svh
// Assertion macros for the HEX record loader
`ifndef INTEL_HEX_RECORD_LOADER_ASSERT_SVH
`define INTEL_HEX_RECORD_LOADER_ASSERT_SVH

`ifndef SYNTHESIS
`define IHRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ihrl assertion failed");
`define IHRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ihrl assertion failed");
`else
`define IHRL_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define IHRL_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hw/rtl/ihrl_pkg.sv
package ihrl_pkg;

    typedef enum logic [2:0] {
        PH_LINE_START,
        PH_HEADER,
        PH_DATA,
        PH_SKIP,
        PH_HALTED
    } t_phase;

    typedef struct packed {
        logic        is_error;
        logic        error_kind;
        logic [15:0] offset;
        logic [7:0]  index;
        logic [7:0]  data;
    } t_job;

    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] REC_TYPE_DATA = 8'h00;
    localparam logic [3:0] HDR_LAST      = 4'd7;
    localparam logic       ERR_HEADER    = 1'b0;
    localparam logic       ERR_DATA      = 1'b1;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // bit 4 set when c is a hex digit, low nibble holds its value
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c inside {[8'h30:8'h39]}) begin
            r = {1'b1, c[3:0]};
        end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/ihrl_front.sv
module ihrl_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_char,
    input  logic          i_full,
    output logic          o_push,
    output ihrl_pkg::t_job o_job
);
    import ihrl_pkg::*;

    t_phase      r_phase,    n_phase;
    logic [3:0]  r_hdr_cnt,  n_hdr_cnt;
    logic [31:0] r_hdr,      n_hdr;
    logic [7:0]  r_byte_cnt, n_byte_cnt;
    logic [15:0] r_offset,   n_offset;
    logic [7:0]  r_index,    n_index;
    logic [3:0]  r_upper,    n_upper;
    logic        r_pending,  n_pending;

    logic        w_accept;
    logic [4:0]  w_hex;
    logic [31:0] w_hdr_full;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;
    assign w_hex    = hex_decode(i_char);
    assign w_hdr_full = {r_hdr[27:0], w_hex[3:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_LINE_START;
            r_hdr_cnt  <= '0;
            r_hdr      <= '0;
            r_byte_cnt <= '0;
            r_offset   <= '0;
            r_index    <= '0;
            r_upper    <= '0;
            r_pending  <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_hdr_cnt  <= n_hdr_cnt;
            r_hdr      <= n_hdr;
            r_byte_cnt <= n_byte_cnt;
            r_offset   <= n_offset;
            r_index    <= n_index;
            r_upper    <= n_upper;
            r_pending  <= n_pending;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_hdr_cnt  = r_hdr_cnt;
        n_hdr      = r_hdr;
        n_byte_cnt = r_byte_cnt;
        n_offset   = r_offset;
        n_index    = r_index;
        n_upper    = r_upper;
        n_pending  = r_pending;
        o_push     = 1'b0;
        o_job      = '0;
        if (w_accept) begin
            case (r_phase)
                PH_LINE_START: begin
                    if (i_char == CH_COLON) begin
                        n_phase   = PH_HEADER;
                        n_hdr_cnt = '0;
                        n_hdr     = '0;
                    end else if (i_char != CH_NEWLINE) begin
                        n_phase = PH_SKIP;
                    end
                end
                PH_HEADER: begin
                    if (!w_hex[4]) begin
                        o_push           = 1'b1;
                        o_job.is_error   = 1'b1;
                        o_job.error_kind = ERR_HEADER;
                        n_phase          = PH_HALTED;
                    end else begin
                        n_hdr     = w_hdr_full;
                        n_hdr_cnt = r_hdr_cnt + 4'd1;
                        if (r_hdr_cnt == HDR_LAST) begin
                            n_byte_cnt = w_hdr_full[31:24];
                            n_offset   = w_hdr_full[23:8];
                            n_index    = '0;
                            n_pending  = 1'b0;
                            n_upper    = '0;
                            if (w_hdr_full[7:0] == REC_TYPE_DATA &&
                                w_hdr_full[31:24] != 8'd0) begin
                                n_phase = PH_DATA;
                            end else begin
                                n_phase = PH_SKIP;
                            end
                        end
                    end
                end
                PH_DATA: begin
                    if (!w_hex[4]) begin
                        o_push           = 1'b1;
                        o_job.is_error   = 1'b1;
                        o_job.error_kind = ERR_DATA;
                        n_phase          = PH_HALTED;
                    end else if (!r_pending) begin
                        n_upper   = w_hex[3:0];
                        n_pending = 1'b1;
                    end else begin
                        o_push       = 1'b1;
                        o_job.offset = r_offset;
                        o_job.index  = r_index;
                        o_job.data   = {r_upper, w_hex[3:0]};
                        n_pending    = 1'b0;
                        n_index      = r_index + 8'd1;
                        if (n_index == r_byte_cnt) begin
                            n_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (i_char == CH_NEWLINE) begin
                        n_phase = PH_LINE_START;
                    end
                end
                default: begin
                    n_phase = PH_HALTED;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/ihrl_queue.sv
module ihrl_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ihrl_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output ihrl_pkg::t_job o_job,
    output logic [ihrl_pkg::Q_CNT_W-1:0] o_count
);
    import ihrl_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/ihrl_back.sv
module ihrl_back #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [31:0]    i_cfg_wdata,
    input  logic           i_empty,
    input  ihrl_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [39:0]    o_data,
    output logic [1:0]     o_user
);
    import ihrl_pkg::*;

    localparam int SW = (ADDR_WIDTH > 32) ? ADDR_WIDTH : 32;
    localparam logic [SW-1:0] A_MASK = {SW{1'b1}} >> (SW - ADDR_WIDTH);

    logic [31:0]   r_base;
    logic          r_valid;
    logic [39:0]   r_data;
    logic [1:0]    r_user;
    logic [SW-1:0] w_sum;
    logic [SW-1:0] w_addr;

    assign o_pop   = !i_empty && (!r_valid || i_ready);
    assign w_sum   = SW'(r_base) + SW'(i_job.offset) + SW'(i_job.index);
    assign w_addr  = w_sum & A_MASK;
    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_user  = r_user;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_user <= {i_job.error_kind, i_job.is_error};
            if (i_job.is_error) begin
                r_data <= '0;
            end else begin
                r_data <= {i_job.data, w_addr[31:0]};
            end
        end
    end

endmodule

FILE: hw/rtl/intel_hex_record_loader.sv
// Intel HEX record loader.
// Slave stream (i_s_*) takes one ASCII character of a HEX file per beat.
// Master stream (o_m_*) gives one beat per decoded data byte, or one error
// beat when a non-hex character stands where a header or data digit is due.
// i_cfg_we / i_cfg_wdata write the 32-bit base address added to each record
// offset; write it only while no character is in flight.
// Throughput: one character per cycle while the queue is not full.
// Path of a result: the parser writes it into the queue when it accepts the
// character completing it, and the queue loads it into the output register
// once that register is empty or being taken.
// When the receiver stalls, a two-entry queue and the output register absorb
// results; o_s_tready falls only when the queue is full.
// After an error beat the block drops all further characters until reset.
// Reset (i_rst_n low, synchronous) returns the parser to line start, empties
// the queue and output register and clears the base address to zero.
`include "intel_hex_record_loader_assert.svh"

module intel_hex_record_loader #(
    parameter int ADDR_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_in
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] write_address, [39:32] write_data
    output logic [1:0]  o_m_tuser,   // [0] is_error, [1] error_kind
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata
);
    import ihrl_pkg::*;

    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    t_job               w_push_job;
    t_job               w_head_job;
    logic [Q_CNT_W-1:0] w_count;

    ihrl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_char  (i_s_tdata),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_push_job)
    );

    ihrl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_head_job),
        .o_count (w_count)
    );

    ihrl_back #(
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_empty     (w_empty),
        .i_job       (w_head_job),
        .o_pop       (w_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_data      (o_m_tdata),
        .o_user      (o_m_tuser)
    );

    `IHRL_ASSERT_NOW(a_push_has_room, i_clk, i_rst_n, w_push, !w_full)
    `IHRL_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, w_count <= Q_CNT_W'(Q_DEPTH))
    `IHRL_ASSERT_NEXT(a_halt_after_error, i_clk, i_rst_n, o_m_tvalid && i_m_tready && o_m_tuser[0], !o_m_tvalid)

endmodule

FILE: sim/ihrl_write_checker.sv
`timescale 1ns / 100ps

module ihrl_write_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    output int          o_pending,
    output int          o_fail_count
);
    import ihrl_pkg::*;

    localparam int         MAX_REPORTS   = 10;

    typedef struct packed {
        logic        is_error;
        logic        kind;
        logic [31:0] addr;
        logic [7:0]  data;
    } t_write_beat;

    t_write_beat expected_writes[$];

    t_phase      phase;
    logic [3:0]  hdr_cnt;
    logic [31:0] hdr_sr;
    logic [7:0]  rec_len;
    logic [15:0] rec_off;
    logic [7:0]  byte_idx;
    logic [3:0]  hi_nib;
    logic        hi_valid;
    logic [31:0] base_addr;
    int          fails = 0;

    assign o_fail_count = fails;

    function automatic bit is_hex_digit(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic logic [3:0] hex_digit_value(input logic [7:0] c);
        if (c <= "9") begin
            return 4'(c - "0");
        end else if (c >= "a") begin
            return 4'(c - "a" + 8'd10);
        end
        return 4'(c - "A" + 8'd10);
    endfunction

    task automatic parse_char(input logic [7:0] c);
        t_write_beat beat;
        logic [3:0]  nib;
        beat = '0;
        nib  = hex_digit_value(c);
        case (phase)
            PH_LINE_START: begin
                if (c == CH_COLON) begin
                    phase   = PH_HEADER;
                    hdr_cnt = '0;
                    hdr_sr  = '0;
                end else if (c != CH_NEWLINE) begin
                    phase = PH_SKIP;
                end
            end
            PH_HEADER: begin
                if (!is_hex_digit(c)) begin
                    beat.is_error = 1'b1;
                    beat.kind     = ERR_HEADER;
                    expected_writes.push_back(beat);
                    phase = PH_HALTED;
                end else begin
                    hdr_sr  = {hdr_sr[27:0], nib};
                    hdr_cnt = hdr_cnt + 4'd1;
                    if (hdr_cnt == 4'd8) begin
                        rec_len  = hdr_sr[31:24];
                        rec_off  = hdr_sr[23:8];
                        byte_idx = '0;
                        hi_nib   = '0;
                        hi_valid = 1'b0;
                        if (hdr_sr[7:0] == REC_TYPE_DATA && rec_len != 8'd0) begin
                            phase = PH_DATA;
                        end else begin
                            phase = PH_SKIP;
                        end
                    end
                end
            end
            PH_DATA: begin
                if (!is_hex_digit(c)) begin
                    beat.is_error = 1'b1;
                    beat.kind     = ERR_DATA;
                    expected_writes.push_back(beat);
                    phase = PH_HALTED;
                end else if (!hi_valid) begin
                    hi_nib   = nib;
                    hi_valid = 1'b1;
                end else begin
                    beat.addr = base_addr + 32'(rec_off) + 32'(byte_idx);
                    beat.data = {hi_nib, nib};
                    expected_writes.push_back(beat);
                    hi_valid = 1'b0;
                    byte_idx = byte_idx + 8'd1;
                    if (byte_idx == rec_len) begin
                        phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                if (c == CH_NEWLINE) begin
                    phase = PH_LINE_START;
                end
            end
            default: begin
            end
        endcase
    endtask

    task automatic check_beat();
        t_write_beat got;
        t_write_beat want;
        got.is_error = i_m_tuser[0];
        got.kind     = i_m_tuser[1];
        got.addr     = i_m_tdata[31:0];
        got.data     = i_m_tdata[39:32];
        if (expected_writes.size() == 0) begin
            fails++;
            if (fails <= MAX_REPORTS) begin
                $display("%0t unexpected beat: err=%0b kind=%0b addr=%h data=%h",
                         $realtime, got.is_error, got.kind, got.addr, got.data);
            end
        end else begin
            want = expected_writes.pop_front();
            if (got.is_error !== want.is_error || got.kind !== want.kind ||
                got.addr !== want.addr || got.data !== want.data) begin
                fails++;
                if (fails <= MAX_REPORTS) begin
                    $display("%0t mismatch: exp err=%0b kind=%0b addr=%h data=%h",
                             $realtime, want.is_error, want.kind, want.addr, want.data);
                    $display("%0t           got err=%0b kind=%0b addr=%h data=%h",
                             $realtime, got.is_error, got.kind, got.addr, got.data);
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            phase     = PH_LINE_START;
            hdr_cnt   = '0;
            hdr_sr    = '0;
            rec_len   = '0;
            rec_off   = '0;
            byte_idx  = '0;
            hi_nib    = '0;
            hi_valid  = 1'b0;
            base_addr = '0;
            expected_writes.delete();
        end else begin
            if (i_cfg_we) begin
                base_addr = i_cfg_wdata;
            end
            if (i_s_tvalid && i_s_tready) begin
                parse_char(i_s_tdata);
            end
            if (i_m_tvalid && i_m_tready) begin
                check_beat();
            end
        end
        o_pending <= expected_writes.size();
    end

endmodule

FILE: sim/tb_intel_hex_record_loader.sv
`timescale 1ns / 100ps

module tb_intel_hex_record_loader;
    import ihrl_pkg::*;

    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam int         STALL_CYCLES  = 80;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         DRAIN_CYCLES  = 20;
    localparam int         TIMEOUT_NS    = 400_000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    int          pending;
    int          fail_count;
    int          r_len;

    bit          stall_req  = 1'b0;
    bit          stall_done = 1'b0;
    logic [7:0]  line_buf[$];

    intel_hex_record_loader u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    ihrl_write_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return "0" + 8'(v);
        end else if ($urandom_range(0, 1)) begin
            return "a" + 8'(v - 4'd10);
        end
        return "A" + 8'(v - 4'd10);
    endfunction

    function automatic logic [7:0] any_but_newline();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (c == CH_NEWLINE) c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic void push_hex(input logic [31:0] v, input int digits);
        for (int i = digits - 1; i >= 0; i--) line_buf.push_back(hex_char(v[4*i +: 4]));
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endfunction

    function automatic void push_header(input int n, input logic [7:0] rec_type);
        line_buf.push_back(CH_COLON);
        push_hex(n, 2);
        push_hex($urandom_range(0, 16'hFFFF), 4);
        push_hex(32'(rec_type), 2);
    endfunction

    function automatic void build_data_line(input int n);
        int r;
        push_header(n, REC_TYPE_DATA);
        repeat (n) push_hex($urandom_range(0, 255), 2);
        r = $urandom_range(0, 9);
        if (r < 5) begin
            push_hex($urandom_range(0, 255), 2);
        end else if (r < 8) begin
            push_hex($urandom_range(0, 255), 2);
            line_buf.push_back(CH_CR);
        end else begin
            repeat ($urandom_range(1, 3)) line_buf.push_back(any_but_newline());
        end
        line_buf.push_back(CH_NEWLINE);
    endfunction

    function automatic void build_random_line();
        int         r;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            build_data_line(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6));
            return;
        end
        if (r < 78) begin
            push_header($urandom_range(0, 8), 8'($urandom_range(1, 255)));
            repeat ($urandom_range(0, 12)) line_buf.push_back(any_but_newline());
        end else if (r < 86) begin
            line_buf.push_back(CH_HASH);
            repeat ($urandom_range(0, 8)) line_buf.push_back(any_but_newline());
        end else if (r >= 92) begin
            c = any_but_newline();
            while (c == CH_COLON) c = any_but_newline();
            line_buf.push_back(c);
            repeat ($urandom_range(0, 8)) line_buf.push_back(any_but_newline());
        end
        line_buf.push_back(CH_NEWLINE);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 25);
    endfunction

    task automatic put_char(input logic [7:0] c, input bit steady);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_line(input bit steady);
        foreach (line_buf[i]) put_char(line_buf[i], steady);
        line_buf.delete();
    endtask

    task automatic random_phase(input int n_chars);
        int sent;
        sent = 0;
        while (sent < n_chars) begin
            build_random_line();
            sent += line_buf.size();
            send_line($urandom_range(0, 3) == 0);
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_base(input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int r;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (stall_req && !stall_done) begin
                m_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                stall_done = 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    m_tready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end else if (r < 95) begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end else begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(8, 30)) @(posedge clk);
                end
            end
        end
    end

    initial begin
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        rst_n     <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // wrap past the top of the address space
        load_base(32'hFFFF_FFF0);
        line_buf.push_back(CH_NEWLINE);
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h00);
        line_buf.push_back(CH_NEWLINE);
        line_buf.push_back(CH_HASH);
        line_buf.push_back(CH_NEWLINE);
        push_text(":00ABCD00");
        line_buf.push_back(CH_NEWLINE);
        push_text(":03FFFF0000fFa5");
        line_buf.push_back(CH_NEWLINE);
        send_line(1'b0);

        wait_idle();
        load_base(32'h0000_0000);
        random_phase(120);

        // hold the receiver off through a long record
        wait_idle();
        load_base(32'hFFFF_FFFF);
        stall_req = 1'b1;
        build_data_line(24);
        send_line(1'b1);
        random_phase(80);

        wait_idle();
        load_base(32'($urandom));
        random_phase(120);

        // one parse failure ends the stream; later characters must be dropped
        wait_idle();
        if ($urandom_range(0, 1)) begin
            line_buf.push_back(CH_COLON);
            repeat ($urandom_range(0, 7)) line_buf.push_back(hex_char(4'($urandom)));
        end else begin
            r_len = $urandom_range(1, 4);
            push_header(r_len, REC_TYPE_DATA);
            repeat ($urandom_range(0, 2 * r_len - 1))
                line_buf.push_back(hex_char(4'($urandom)));
        end
        line_buf.push_back($urandom_range(0, 1) ? CH_NEWLINE : non_hex_char());
        line_buf.push_back(CH_NEWLINE);
        build_data_line(2);
        send_line(1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: intel_hex_record_loader.f
+incdir+hw/rtl
hw/rtl/ihrl_pkg.sv
hw/rtl/ihrl_front.sv
hw/rtl/ihrl_queue.sv
hw/rtl/ihrl_back.sv
hw/rtl/intel_hex_record_loader.sv
sim/ihrl_write_checker.sv
sim/tb_intel_hex_record_loader.sv
